// File: rtl/core/s256mh_pkg.sv
package s256mh_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned NUM_DIGEST = 8;

    localparam word_t H_INIT [NUM_DIGEST] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t K_ROUND [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// File: rtl/core/sha256_message_hash.sv
// SHA-256 hash of a byte stream. Each request on the slave side carries one message
// byte (tdata), a byte-valid flag (tuser) and an end-of-message flag (tlast); a request
// with tuser low and tlast high finishes the message as it stands, so an empty message
// is allowed. Each byte shifts into the block buffer; every 64th byte of the padded
// message starts a compression, one SHA-256 round per cycle through a single round
// unit, then a fold step that adds the result into the chaining words. The final request
// adds padding one byte per cycle (9 to 72 bytes, so one or two compressions) and then
// the digest leaves on the master side as eight 32-bit words, word 0 first, with the
// word index in tuser and tlast on word 7. The block takes no request during a
// compression, the padding or the digest output, and is ready for a new message
// straight after the last digest word is taken. There is no clearing pass after reset.
module sha256_message_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]              state_reg, state_next;
    s256mh_pkg::word_t       chain_reg [8];
    s256mh_pkg::word_t       chain_next [8];
    s256mh_pkg::word_t       vars_reg [8];
    s256mh_pkg::word_t       vars_next [8];
    logic [511:0]            blk_reg, blk_next;
    logic [63:0]             bitcnt_reg, bitcnt_next;
    logic [5:0]              pos_reg, pos_next;
    logic [5:0]              rnd_reg, rnd_next;
    logic [2:0]              idx_reg, idx_next;
    logic                    pad_reg, pad_next;
    logic                    first_reg, first_next;
    logic                    len_reg, len_next;
    logic                    fin_reg, fin_next;

    logic                    byte_we;
    logic [7:0]              byte_val;
    logic                    start;
    logic                    in_len;
    s256mh_pkg::word_t       w_new, t1, t2, ch, mj;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = chain_reg[idx_reg];
    assign m_axis_tuser  = idx_reg;
    assign m_axis_tlast  = (idx_reg == 3'd7);

    // round unit: window word 0 is W[t], the new word is W[t+16]
    always_comb
    begin
        w_new = s256mh_pkg::ssig1(blk_reg[511-32*14 -: 32]) + blk_reg[511-32*9 -: 32]
              + s256mh_pkg::ssig0(blk_reg[511-32*1 -: 32]) + blk_reg[511:480];
        ch = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        mj = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
           ^ (vars_reg[1] & vars_reg[2]);
        t1 = vars_reg[7] + s256mh_pkg::bsig1(vars_reg[4]) + ch
           + s256mh_pkg::K_ROUND[rnd_reg] + blk_reg[511:480];
        t2 = s256mh_pkg::bsig0(vars_reg[0]) + mj;
    end

    // length bytes go out once the zero fill has reached byte 56
    assign in_len = len_reg || (!first_reg && (pos_reg == 6'd56));

    always_comb
    begin
        state_next  = state_reg;
        chain_next  = chain_reg;
        vars_next   = vars_reg;
        blk_next    = blk_reg;
        bitcnt_next = bitcnt_reg;
        pos_next    = pos_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        pad_next    = pad_reg;
        first_next  = first_reg;
        len_next    = len_reg;
        fin_next    = fin_reg;
        byte_we     = 1'b0;
        byte_val    = 8'h00;
        start       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser)
                    begin
                        byte_we     = 1'b1;
                        byte_val    = s_axis_tdata;
                        bitcnt_next = bitcnt_reg + 64'd8;
                    end
                    if (s_axis_tlast)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                    if (s_axis_tuser && (pos_reg == 6'd63))
                        start = 1'b1;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                byte_we    = 1'b1;
                first_next = 1'b0;
                if (first_reg)
                    byte_val = s256mh_pkg::PAD_BYTE;
                else if (in_len)
                    byte_val = bitcnt_reg[{~pos_reg[2:0], 3'b000} +: 8];
                if (in_len && !first_reg)
                    len_next = 1'b1;
                if (pos_reg == 6'd63)
                begin
                    start = 1'b1;
                    if (in_len && !first_reg)
                        fin_next = 1'b1;
                end
            end
            ST_ROUND:
            begin
                blk_next     = {blk_reg[479:0], w_new};
                vars_next[7] = vars_reg[6];
                vars_next[6] = vars_reg[5];
                vars_next[5] = vars_reg[4];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[3] = vars_reg[2];
                vars_next[2] = vars_reg[1];
                vars_next[1] = vars_reg[0];
                vars_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                if (fin_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = 3'd0;
                end
                else if (pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        chain_next  = s256mh_pkg::H_INIT;
                        bitcnt_next = 64'd0;
                        pos_next    = 6'd0;
                        pad_next    = 1'b0;
                        first_next  = 1'b0;
                        len_next    = 1'b0;
                        fin_next    = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (byte_we)
        begin
            blk_next = {blk_reg[503:0], byte_val};
            pos_next = pos_reg + 6'd1;
        end
        if (start)
        begin
            vars_next  = chain_reg;
            rnd_next   = 6'd0;
            state_next = ST_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chain_reg  <= s256mh_pkg::H_INIT;
            bitcnt_reg <= 64'd0;
            pos_reg    <= 6'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            len_reg    <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            chain_reg  <= chain_next;
            bitcnt_reg <= bitcnt_next;
            pos_reg    <= pos_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            first_reg  <= first_next;
            len_reg    <= len_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg <= vars_next;
        blk_reg  <= blk_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request taken while digest output is active");

    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> ($past(state_reg) == ST_ROUND && $past(rnd_reg) == 6'd63))
        else $error("chaining update without a full set of rounds");

    a_out_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT) |-> (pos_reg == 6'd0 && len_reg))
        else $error("digest output before padded block completed");

    a_clean_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
        |=> (state_reg == ST_IDLE && pos_reg == 6'd0 && bitcnt_reg == 64'd0 && !pad_reg))
        else $error("message state not cleared after digest");

endmodule
